[hw/rtl/grr_pkg.sv]
package grr_pkg;

    // glyph geometry
    localparam int MAX_GLYPH_WIDTH = 32;
    localparam int COL_W           = $clog2(MAX_GLYPH_WIDTH) + 1;
    localparam int CALC_W          = COL_W + 2;  // column math incl. base + 8
    localparam int BYTE_BITS       = 8;
    localparam int BYTE_MSB        = 7;
    localparam int MAX_RUNS        = 5;
    localparam int RUN_IDX_W       = $clog2(MAX_RUNS + 1);

    // run queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // signed clip arithmetic
    localparam int CLIP_W = 14;

    // stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_DATA_W  = 11;

    // clamp limits
    localparam logic [4:0]  SCALE_MIN  = 5'd1;
    localparam logic [4:0]  SCALE_MAX  = 5'd16;
    localparam logic [10:0] SCREEN_MIN = 11'd1;
    localparam logic [10:0] SCREEN_MAX = 11'd1024;

    // register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_TEXT_SCALE    = 2'd0;
    localparam cfg_idx_t REG_BOLD_ENABLE   = 2'd1;
    localparam cfg_idx_t REG_SCREEN_WIDTH  = 2'd2;
    localparam cfg_idx_t REG_SCREEN_HEIGHT = 2'd3;

    typedef struct packed {
        logic [4:0]  scale;   // already clamped to 1..16
        logic        bold;
        logic [10:0] sw;      // already clamped to 1..1024
        logic [10:0] sh;
    } cfg_t;

    // all closed runs of one input byte
    typedef struct packed {
        logic signed [10:0]                  left;
        logic signed [10:0]                  top;
        logic [4:0]                          row;
        logic [RUN_IDX_W-1:0]                cnt;
        logic [MAX_RUNS-1:0][COL_W-1:0]      start;
        logic [MAX_RUNS-1:0][COL_W-1:0]      len;
    } run_set_t;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [10:0] w;
        logic [4:0]  h;
    } rect_t;

endpackage

[hw/rtl/glyph_run_rasterizer.sv]
// Glyph run rasterizer: bitmap row bytes in, clipped fill rectangles out.
// Path from item accept to m_*: run queue, then the scale, hold and out registers;
//   a rect sits longer in hold until its byte's last flag is known.
// Throughput: one item per cycle into a 4-deep run queue while it is not full; the back
//   end clips one run per cycle unless m_* stalls; bytes with no run cost it nothing.
// Reset (aresetn low, sync): queue, pipeline, open run cleared; scale 1, bold off, 160 x 80.
module glyph_run_rasterizer
    import grr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // input items
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // glyph_left[10:0], glyph_top[21:11], glyph_width[27:22], glyph_row[32:28],
    // byte_index[34:33], row_bits[42:35], zero fill
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    // result items
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // rect_x[9:0], rect_y[19:10], rect_w[30:20], rect_h[35:31], zero fill
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tlast,   // last_rect
    // configuration writes
    input  logic                    cfg_wr_en,
    input  cfg_idx_t                cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    cfg_t       cfg_reg, cfg_next;
    logic       in_fire;
    logic       q_push, q_full, q_empty, q_pop;
    run_set_t   q_wdata, q_head;
    rect_t      rect;

    // Config values are clamped on write; the back end uses them as-is.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TEXT_SCALE: begin
                    if (cfg_wdata[4:0] < SCALE_MIN) begin
                        cfg_next.scale = SCALE_MIN;
                    end else if (cfg_wdata[4:0] > SCALE_MAX) begin
                        cfg_next.scale = SCALE_MAX;
                    end else begin
                        cfg_next.scale = cfg_wdata[4:0];
                    end
                end
                REG_BOLD_ENABLE: begin
                    cfg_next.bold = cfg_wdata[0];
                end
                REG_SCREEN_WIDTH: begin
                    if (cfg_wdata < SCREEN_MIN) begin
                        cfg_next.sw = SCREEN_MIN;
                    end else if (cfg_wdata > SCREEN_MAX) begin
                        cfg_next.sw = SCREEN_MAX;
                    end else begin
                        cfg_next.sw = cfg_wdata;
                    end
                end
                REG_SCREEN_HEIGHT: begin
                    if (cfg_wdata < SCREEN_MIN) begin
                        cfg_next.sh = SCREEN_MIN;
                    end else if (cfg_wdata > SCREEN_MAX) begin
                        cfg_next.sh = SCREEN_MAX;
                    end else begin
                        cfg_next.sh = cfg_wdata;
                    end
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale <= SCALE_MIN;
            cfg_reg.bold  <= 1'b0;
            cfg_reg.sw    <= 11'd160;
            cfg_reg.sh    <= 11'd80;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input side only waits on the run queue, never on the output.
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    // Front: run detection and open-run tracking across bytes.
    grr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .glyph_left  (s_tdata[10:0]),
        .glyph_top   (s_tdata[21:11]),
        .glyph_width (s_tdata[27:22]),
        .glyph_row   (s_tdata[32:28]),
        .byte_index  (s_tdata[34:33]),
        .row_bits    (s_tdata[42:35]),
        .push        (q_push),
        .push_data   (q_wdata)
    );

    // Queue of per-byte run sets; bytes with no closed run are not queued.
    grr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    // Back: scale, clip, tag the last surviving rect of each byte.
    grr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (!q_empty),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_rect     (rect),
        .m_last     (m_tlast)
    );

    assign m_tdata = {4'b0000, rect.h, rect.w, rect.y, rect.x};

endmodule

[hw/rtl/grr_front.sv]
module grr_front
    import grr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic signed [10:0] glyph_left,
    input  logic signed [10:0] glyph_top,
    input  logic [5:0]         glyph_width,
    input  logic [4:0]         glyph_row,
    input  logic [1:0]         byte_index,
    input  logic [7:0]         row_bits,
    output logic               push,
    output run_set_t           push_data
);

    logic             run_open_reg, run_open_next;
    logic [COL_W-1:0] run_start_reg, run_start_next;

    logic [CALC_W-1:0]                gw;
    logic [CALC_W-1:0]                base;
    logic [CALC_W-1:0]                col;
    logic                             open;
    logic [COL_W-1:0]                 start;
    logic [RUN_IDX_W-1:0]             n;
    logic [MAX_RUNS-1:0][COL_W-1:0]   st;
    logic [MAX_RUNS-1:0][COL_W-1:0]   ln;

    always_comb begin
        if (int'(glyph_width) > MAX_GLYPH_WIDTH) begin
            gw = CALC_W'(MAX_GLYPH_WIDTH);
        end else begin
            gw = CALC_W'(glyph_width);
        end
        base  = CALC_W'({byte_index, 3'b000});
        open  = run_open_reg && (byte_index != 2'd0);   // new row drops open run
        start = run_start_reg;
        n     = '0;
        st    = '0;
        ln    = '0;
        col   = '0;
        for (int k = 0; k < BYTE_BITS; k++) begin
            col = base + CALC_W'(k);
            if (col < gw) begin
                if (row_bits[k]) begin
                    if (!open) begin
                        open  = 1'b1;
                        start = COL_W'(col);
                    end
                end else if (open) begin
                    // stale start at or past this column gives nothing
                    if (col > CALC_W'(start)) begin
                        st[n] = start;
                        ln[n] = COL_W'(col - CALC_W'(start));
                        n     = n + RUN_IDX_W'(1);
                    end
                    open = 1'b0;
                end
            end
        end
        // byte reaches the glyph edge: close at the width
        if (open && (gw <= base + CALC_W'(BYTE_BITS))) begin
            if (gw > CALC_W'(start)) begin
                st[n] = start;
                ln[n] = COL_W'(gw - CALC_W'(start));
                n     = n + RUN_IDX_W'(1);
            end
            open = 1'b0;
        end
        run_open_next  = open;
        run_start_next = start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
        end else if (in_fire) begin
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
        end
    end

    assign push            = in_fire && (n != '0);
    assign push_data.left  = glyph_left;
    assign push_data.top   = glyph_top;
    assign push_data.row   = glyph_row;
    assign push_data.cnt   = n;
    assign push_data.start = st;
    assign push_data.len   = ln;

endmodule

[hw/rtl/grr_fifo.sv]
module grr_fifo
    import grr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_en,
    input  run_set_t wr_data,
    output logic     full,
    input  logic     rd_en,
    output run_set_t rd_data,
    output logic     empty
);

    run_set_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]       count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (count_reg != (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("run queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (count_reg != '0))
        else $error("run queue read while empty");
`endif

endmodule

[hw/rtl/grr_back.sv]
module grr_back
    import grr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     head_valid,
    input  run_set_t head,
    output logic     pop,
    output logic     m_valid,
    input  logic     m_ready,
    output rect_t    m_rect,
    output logic     m_last
);

    logic [RUN_IDX_W-1:0]      ri_reg, ri_next;

    logic                      p_valid_reg, p_valid_next;
    logic                      p_last_reg, p_last_next;
    logic signed [CLIP_W-1:0]  p_x_reg, p_x_next;
    logic signed [CLIP_W-1:0]  p_y_reg, p_y_next;
    logic signed [CLIP_W-1:0]  p_w_reg, p_w_next;

    logic                      held_valid_reg, held_valid_next;
    logic                      held_closed_reg, held_closed_next;
    rect_t                     held_rect_reg, held_rect_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_last_reg, out_last_next;
    rect_t                     out_rect_reg, out_rect_next;

    logic                      out_ok, push_held, adv, issue, last_run;
    logic [COL_W-1:0]          sel_start, sel_len;
    logic [COL_W+4:0]          prod_x, prod_w;
    logic [9:0]                prod_y;

    logic signed [CLIP_W-1:0]  sw, sh, sc, xc, yc, wc, hc, wf, hf;
    logic                      keep;
    rect_t                     new_rect;

    // ---- clip on the registered products
    always_comb begin
        sw = CLIP_W'(signed'({1'b0, cfg.sw}));
        sh = CLIP_W'(signed'({1'b0, cfg.sh}));
        sc = CLIP_W'(signed'({1'b0, cfg.scale}));
        if (p_x_reg < 0) begin
            xc = '0;
            wc = p_w_reg + p_x_reg;
        end else begin
            xc = p_x_reg;
            wc = p_w_reg;
        end
        if (p_y_reg < 0) begin
            yc = '0;
            hc = sc + p_y_reg;
        end else begin
            yc = p_y_reg;
            hc = sc;
        end
        wf = (xc + wc > sw) ? sw - xc : wc;
        hf = (yc + hc > sh) ? sh - yc : hc;
        keep = (xc < sw) && (yc < sh) && (wf > 0) && (hf > 0);
        new_rect.x = 10'(xc);
        new_rect.y = 10'(yc);
        new_rect.w = 11'(wf);
        new_rect.h = 5'(hf);
    end

    // held rect leaves once a later survivor shows up or its byte is done
    assign out_ok    = !out_valid_reg || m_ready;
    assign push_held = held_valid_reg && (held_closed_reg || (p_valid_reg && keep));
    assign adv       = out_ok || !push_held;

    assign issue    = adv && head_valid;
    assign last_run = (ri_reg == head.cnt - RUN_IDX_W'(1));
    assign pop      = issue && last_run;

    // ---- issue: one run per cycle, scale it
    always_comb begin
        sel_start = head.start[ri_reg];
        sel_len   = head.len[ri_reg];
        prod_x    = (COL_W+5)'(sel_start) * (COL_W+5)'(cfg.scale);
        prod_w    = (COL_W+5)'(sel_len) * (COL_W+5)'(cfg.scale);
        prod_y    = 10'(head.row) * 10'(cfg.scale);

        ri_next      = ri_reg;
        p_valid_next = p_valid_reg;
        p_last_next  = p_last_reg;
        p_x_next     = p_x_reg;
        p_y_next     = p_y_reg;
        p_w_next     = p_w_reg;
        if (adv) begin
            p_valid_next = issue;
            p_last_next  = last_run;
            p_x_next     = CLIP_W'(head.left) + CLIP_W'(signed'({1'b0, prod_x}));
            p_y_next     = CLIP_W'(head.top) + CLIP_W'(signed'({1'b0, prod_y}));
            p_w_next     = CLIP_W'(signed'({1'b0, prod_w}))
                         + CLIP_W'(signed'({1'b0, (cfg.bold && cfg.scale == SCALE_MIN)}));
            if (issue) begin
                ri_next = last_run ? '0 : ri_reg + RUN_IDX_W'(1);
            end
        end
    end

    // ---- hold stage and output register
    always_comb begin
        held_valid_next  = held_valid_reg;
        held_closed_next = held_closed_reg;
        held_rect_next   = held_rect_reg;
        out_valid_next   = out_valid_reg;
        out_last_next    = out_last_reg;
        out_rect_next    = out_rect_reg;
        if (out_ok) begin
            out_valid_next = push_held;
            out_last_next  = held_closed_reg;
            out_rect_next  = held_rect_reg;
        end
        if (adv) begin
            if (p_valid_reg && keep) begin
                held_valid_next  = 1'b1;
                held_closed_next = p_last_reg;
                held_rect_next   = new_rect;
            end else if (push_held) begin
                held_valid_next = 1'b0;
            end else if (p_valid_reg && p_last_reg && held_valid_reg) begin
                held_closed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ri_reg          <= '0;
            p_valid_reg     <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_closed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            ri_reg          <= ri_next;
            p_valid_reg     <= p_valid_next;
            held_valid_reg  <= held_valid_next;
            held_closed_reg <= held_closed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_last_reg    <= p_last_next;
        p_x_reg       <= p_x_next;
        p_y_reg       <= p_y_next;
        p_w_reg       <= p_w_next;
        held_rect_reg <= held_rect_next;
        out_last_reg  <= out_last_next;
        out_rect_reg  <= out_rect_next;
    end

    assign m_valid = out_valid_reg;
    assign m_rect  = out_rect_reg;
    assign m_last  = out_last_reg;

`ifndef ASSERT_OFF
    a_ri_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (ri_reg < head.cnt))
        else $error("run index beyond queued run count");
    a_no_empty_set: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (head.cnt != '0))
        else $error("queued byte without runs");
    a_held_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> (held_rect_reg.w != '0 && held_rect_reg.h != '0))
        else $error("held rect has zero size");
`endif

endmodule
